FILE: hw/rtl/hvn_pkg.sv
// Shared types and constants for the heightmap vertex normal pipeline.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package hvn_pkg;

  // Configuration register width and register indexes
  localparam int REG_W = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_SPACING    = 2'd0,
    REG_COLUMN_SPACING = 2'd1,
    REG_HEIGHT_STEP    = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  // Reset values of the spacing and height step registers (Q8.8)
  localparam logic [REG_W-1:0] ROW_SPACING_RST    = 16'd256;
  localparam logic [REG_W-1:0] COLUMN_SPACING_RST = 16'd256;
  localparam logic [REG_W-1:0] HEIGHT_STEP_RST    = 16'd26;

  // Edge vectors are scaled by this so every component is an integer
  localparam int HEIGHT_DIVISOR = 10;
  // Width of spacing * HEIGHT_DIVISOR
  localparam int SPACE_W = 20;

  // The largest cross product magnitude is normalized into [2^29, 2^30)
  localparam int MAG_W = 30;
  localparam int SQ_W = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int SQRT_STAGES = SUM_W / 2;

  // Result field width on the stream
  localparam int OUT_W = 16;

endpackage

FILE: hw/rtl/hvn_isqrt.sv
// Pipelined floor integer square root, one result bit per stage.
// Depends on hvn_pkg; carries a side payload alongside the operand.
`timescale 1ns / 1ps

module hvn_isqrt #(
  parameter int PW = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [hvn_pkg::SUM_W-1:0]   in_val,
  input  logic [PW-1:0]               in_pl,
  output logic                        out_vld,
  output logic [hvn_pkg::ROOT_W-1:0]  out_root,
  output logic [PW-1:0]               out_pl
);
  import hvn_pkg::*;

  localparam int RW = SUM_W + 1;

  logic              vld_r  [SQRT_STAGES];
  logic [SUM_W-1:0]  val_r  [SQRT_STAGES];
  logic [RW-1:0]     root_r [SQRT_STAGES];
  logic [PW-1:0]     pl_r   [SQRT_STAGES];

  genvar j;
  generate
    for (j = 0; j < SQRT_STAGES; j++) begin : g_stage
      localparam int K = SQRT_STAGES - 1 - j;
      logic [RW-1:0]    bit_c;
      logic             vld_in;
      logic [SUM_W-1:0] val_in;
      logic [RW-1:0]    root_in;
      logic [PW-1:0]    pl_in;
      logic [RW-1:0]    trial;
      logic [SUM_W-1:0] val_nxt;
      logic [RW-1:0]    root_nxt;

      // Select the previous stage or the pipeline input
      if (j == 0) begin : g_first
        assign vld_in  = in_vld;
        assign val_in  = in_val;
        assign root_in = '0;
        assign pl_in   = in_pl;
      end else begin : g_next
        assign vld_in  = vld_r[j-1];
        assign val_in  = val_r[j-1];
        assign root_in = root_r[j-1];
        assign pl_in   = pl_r[j-1];
      end

      assign bit_c = RW'(1) << (2 * K);

      // Try subtracting root + bit, keep the remainder if it fits
      always_comb begin
        trial = root_in + bit_c;
        if ({1'b0, val_in} >= trial) begin
          val_nxt  = SUM_W'({1'b0, val_in} - trial);
          root_nxt = (root_in >> 1) + bit_c;
        end else begin
          val_nxt  = val_in;
          root_nxt = root_in >> 1;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[j] <= 1'b0;
        end else if (en) begin
          vld_r[j] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          val_r[j]  <= val_nxt;
          root_r[j] <= root_nxt;
          pl_r[j]   <= pl_in;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[SQRT_STAGES-1];
  assign out_root = root_r[SQRT_STAGES-1][ROOT_W-1:0];
  assign out_pl   = pl_r[SQRT_STAGES-1];

endmodule

FILE: hw/rtl/hvn_div.sv
// Pipelined rounded division of three normalized magnitudes by a length.
// Depends on hvn_pkg; restoring division, one quotient bit per stage.
`timescale 1ns / 1ps

module hvn_div #(
  parameter int NORMAL_FRAC_BITS = 14,
  parameter int PW = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [hvn_pkg::MAG_W-1:0]         in_m0,
  input  logic [hvn_pkg::MAG_W-1:0]         in_m1,
  input  logic [hvn_pkg::MAG_W-1:0]         in_m2,
  input  logic [hvn_pkg::ROOT_W-1:0]        in_len,
  input  logic [PW-1:0]                     in_pl,
  output logic                              out_vld,
  output logic [NORMAL_FRAC_BITS+1:0]       out_q0,
  output logic [NORMAL_FRAC_BITS+1:0]       out_q1,
  output logic [NORMAL_FRAC_BITS+1:0]       out_q2,
  output logic [PW-1:0]                     out_pl
);
  import hvn_pkg::*;

  localparam int F  = NORMAL_FRAC_BITS;
  localparam int QW = F + 2;
  localparam int NW = MAG_W + F + 1;
  localparam int XW = ROOT_W + 1;

  logic              vld_r [QW];
  logic [XW-1:0]     rem_r [QW][3];
  logic [NW-1:0]     num_r [QW][3];
  logic [QW-1:0]     q_r   [QW][3];
  logic [ROOT_W-1:0] len_r [QW];
  logic [PW-1:0]     pl_r  [QW];

  logic [NW-1:0] num_in [3];
  logic [MAG_W-1:0] m_in [3];

  assign m_in[0] = in_m0;
  assign m_in[1] = in_m1;
  assign m_in[2] = in_m2;

  // Numerator with the half-length rounding term folded in
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_in[k] = (NW'(m_in[k]) << F) + NW'(in_len >> 1);
    end
  end

  genvar j;
  generate
    for (j = 0; j < QW; j++) begin : g_stage
      localparam int I = QW - 1 - j;
      logic              vld_in;
      logic [XW-1:0]     rem_in [3];
      logic [NW-1:0]     num_st [3];
      logic [QW-1:0]     q_in   [3];
      logic [ROOT_W-1:0] len_in;
      logic [PW-1:0]     pl_in;
      logic [XW:0]       trial  [3];
      logic [XW-1:0]     rem_nxt [3];
      logic [QW-1:0]     q_nxt  [3];

      // Select the previous stage or the pipeline input
      if (j == 0) begin : g_first
        always_comb begin
          for (int k = 0; k < 3; k++) begin
            rem_in[k] = XW'(num_in[k] >> QW);
            num_st[k] = num_in[k];
            q_in[k]   = '0;
          end
        end
        assign vld_in = in_vld;
        assign len_in = in_len;
        assign pl_in  = in_pl;
      end else begin : g_next
        always_comb begin
          for (int k = 0; k < 3; k++) begin
            rem_in[k] = rem_r[j-1][k];
            num_st[k] = num_r[j-1][k];
            q_in[k]   = q_r[j-1][k];
          end
        end
        assign vld_in = vld_r[j-1];
        assign len_in = len_r[j-1];
        assign pl_in  = pl_r[j-1];
      end

      // Shift in the next numerator bit and subtract the length if it fits
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          trial[k] = {rem_in[k], num_st[k][I]};
          q_nxt[k] = q_in[k];
          if (trial[k] >= (XW+1)'(len_in)) begin
            rem_nxt[k]  = XW'(trial[k] - (XW+1)'(len_in));
            q_nxt[k][I] = 1'b1;
          end else begin
            rem_nxt[k] = XW'(trial[k]);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[j] <= 1'b0;
        end else if (en) begin
          vld_r[j] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < 3; k++) begin
            rem_r[j][k] <= rem_nxt[k];
            num_r[j][k] <= num_st[k];
            q_r[j][k]   <= q_nxt[k];
          end
          len_r[j] <= len_in;
          pl_r[j]  <= pl_in;
        end
      end
    end
  endgenerate

  assign out_vld = vld_r[QW-1];
  assign out_q0  = q_r[QW-1][0];
  assign out_q1  = q_r[QW-1][1];
  assign out_q2  = q_r[QW-1][2];
  assign out_pl  = pl_r[QW-1];

endmodule

FILE: hw/rtl/hvn_face.sv
// One face normal: edge products, cross product, normalize, root, divide.
// Depends on hvn_pkg, hvn_isqrt and hvn_div.
`timescale 1ns / 1ps

module hvn_face #(
  parameter int HEIGHT_BITS = 8,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic                               in_tag,
  input  logic [HEIGHT_BITS-1:0]             h_o,
  input  logic [HEIGHT_BITS-1:0]             h_r,
  input  logic [HEIGHT_BITS-1:0]             h_q,
  input  logic                               row_prev,
  input  logic                               col_prev,
  input  logic [hvn_pkg::REG_W-1:0]          row_spacing,
  input  logic [hvn_pkg::REG_W-1:0]          column_spacing,
  input  logic [hvn_pkg::REG_W-1:0]          height_step,
  output logic                               out_vld,
  output logic                               out_tag,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_nx,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_ny,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_nz
);
  import hvn_pkg::*;

  localparam int HB  = HEIGHT_BITS;
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int DW  = HB + 1;
  localparam int AYW = HB + REG_W;
  localparam int CW  = AYW + SPACE_W;
  localparam int MSW = $clog2(CW);
  localparam int QW  = F + 2;
  localparam int SQ_PW = 2 + 3 + 3 * MAG_W;
  localparam int DV_PW = 5;
  localparam logic [MSW-1:0] TOP_POS = MSW'(MAG_W - 1);

  // Stage 1: height differences times height step, spacings times ten
  logic signed [DW-1:0] dr, dq;
  logic [HB-1:0]        dr_mag, dq_mag;
  logic                 s1_vld_r, s1_tag_r;
  logic [AYW-1:0]       s1_ay_r, s1_by_r;
  logic [SPACE_W-1:0]   s1_ax_r, s1_bz_r;
  logic                 s1_say_r, s1_sby_r, s1_sax_r, s1_sbz_r;

  always_comb begin
    dr = $signed({1'b0, h_r}) - $signed({1'b0, h_o});
    dq = $signed({1'b0, h_q}) - $signed({1'b0, h_o});
    dr_mag = dr[DW-1] ? HB'(-dr) : dr[HB-1:0];
    dq_mag = dq[DW-1] ? HB'(-dq) : dq[HB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag_r <= in_tag;
      s1_ay_r  <= AYW'(dr_mag) * AYW'(height_step);
      s1_by_r  <= AYW'(dq_mag) * AYW'(height_step);
      s1_ax_r  <= SPACE_W'(row_spacing) * SPACE_W'(HEIGHT_DIVISOR);
      s1_bz_r  <= SPACE_W'(column_spacing) * SPACE_W'(HEIGHT_DIVISOR);
      s1_say_r <= dr[DW-1];
      s1_sby_r <= dq[DW-1];
      s1_sax_r <= row_prev;
      s1_sbz_r <= ~col_prev;
    end
  end

  // Stage 2: cross product magnitudes and signs
  logic           s2_vld_r, s2_tag_r;
  logic [CW-1:0]  s2_c0_r, s2_c1_r, s2_c2_r;
  logic           s2_s0_r, s2_s1_r, s2_s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tag_r <= s1_tag_r;
      s2_c0_r  <= CW'(s1_ay_r) * CW'(s1_bz_r);
      s2_c1_r  <= CW'(s1_ax_r) * CW'(s1_bz_r);
      s2_c2_r  <= CW'(s1_ax_r) * CW'(s1_by_r);
      s2_s0_r  <= s1_say_r ^ s1_sbz_r;
      s2_s1_r  <= ~(s1_sax_r ^ s1_sbz_r);
      s2_s2_r  <= s1_sax_r ^ s1_sby_r;
    end
  end

  // Stage 3: largest magnitude
  logic           s3_vld_r, s3_tag_r;
  logic [CW-1:0]  s3_c0_r, s3_c1_r, s3_c2_r, s3_top_r;
  logic           s3_s0_r, s3_s1_r, s3_s2_r;
  logic [CW-1:0]  top01;

  assign top01 = (s2_c0_r > s2_c1_r) ? s2_c0_r : s2_c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tag_r <= s2_tag_r;
      s3_c0_r  <= s2_c0_r;
      s3_c1_r  <= s2_c1_r;
      s3_c2_r  <= s2_c2_r;
      s3_top_r <= (top01 > s2_c2_r) ? top01 : s2_c2_r;
      s3_s0_r  <= s2_s0_r;
      s3_s1_r  <= s2_s1_r;
      s3_s2_r  <= s2_s2_r;
    end
  end

  // Stage 4: leading one position of the largest magnitude
  function automatic logic [MSW-1:0] lead_pos(input logic [CW-1:0] v);
    logic [MSW-1:0] p;
    p = '0;
    for (int i = 0; i < CW; i++) begin
      if (v[i]) p = MSW'(i);
    end
    return p;
  endfunction

  logic           s4_vld_r, s4_tag_r, s4_zero_r;
  logic [CW-1:0]  s4_c0_r, s4_c1_r, s4_c2_r;
  logic [MSW-1:0] s4_pos_r;
  logic           s4_s0_r, s4_s1_r, s4_s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_tag_r  <= s3_tag_r;
      s4_zero_r <= (s3_top_r == '0);
      s4_pos_r  <= lead_pos(s3_top_r);
      s4_c0_r   <= s3_c0_r;
      s4_c1_r   <= s3_c1_r;
      s4_c2_r   <= s3_c2_r;
      s4_s0_r   <= s3_s0_r;
      s4_s1_r   <= s3_s1_r;
      s4_s2_r   <= s3_s2_r;
    end
  end

  // Stage 5: shift all three so the largest lands in [2^29, 2^30)
  function automatic logic [MAG_W-1:0] norm_mag(input logic [CW-1:0] m,
                                                input logic [MSW-1:0] p);
    logic [CW-1:0] t;
    if (p >= TOP_POS) begin
      t = m >> (p - TOP_POS);
    end else begin
      t = m << (TOP_POS - p);
    end
    return t[MAG_W-1:0];
  endfunction

  logic             s5_vld_r, s5_tag_r, s5_zero_r;
  logic [MAG_W-1:0] s5_m0_r, s5_m1_r, s5_m2_r;
  logic             s5_s0_r, s5_s1_r, s5_s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_tag_r  <= s4_tag_r;
      s5_zero_r <= s4_zero_r;
      s5_m0_r   <= norm_mag(s4_c0_r, s4_pos_r);
      s5_m1_r   <= norm_mag(s4_c1_r, s4_pos_r);
      s5_m2_r   <= norm_mag(s4_c2_r, s4_pos_r);
      s5_s0_r   <= s4_s0_r;
      s5_s1_r   <= s4_s1_r;
      s5_s2_r   <= s4_s2_r;
    end
  end

  // Stage 6: squares
  logic             s6_vld_r, s6_tag_r, s6_zero_r;
  logic [MAG_W-1:0] s6_m0_r, s6_m1_r, s6_m2_r;
  logic [SQ_W-1:0]  s6_q0_r, s6_q1_r, s6_q2_r;
  logic             s6_s0_r, s6_s1_r, s6_s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_tag_r  <= s5_tag_r;
      s6_zero_r <= s5_zero_r;
      s6_m0_r   <= s5_m0_r;
      s6_m1_r   <= s5_m1_r;
      s6_m2_r   <= s5_m2_r;
      s6_q0_r   <= SQ_W'(s5_m0_r) * SQ_W'(s5_m0_r);
      s6_q1_r   <= SQ_W'(s5_m1_r) * SQ_W'(s5_m1_r);
      s6_q2_r   <= SQ_W'(s5_m2_r) * SQ_W'(s5_m2_r);
      s6_s0_r   <= s5_s0_r;
      s6_s1_r   <= s5_s1_r;
      s6_s2_r   <= s5_s2_r;
    end
  end

  // Stage 7: sum of squares
  logic             s7_vld_r;
  logic [SUM_W-1:0] s7_sum_r;
  logic [SQ_PW-1:0] s7_pl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_sum_r <= SUM_W'(s6_q0_r) + SUM_W'(s6_q1_r) + SUM_W'(s6_q2_r);
      s7_pl_r  <= {s6_tag_r, s6_zero_r, s6_s0_r, s6_s1_r, s6_s2_r,
                   s6_m0_r, s6_m1_r, s6_m2_r};
    end
  end

  // Length as floor square root
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic [SQ_PW-1:0]  sq_pl;

  hvn_isqrt #(
    .PW (SQ_PW)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s7_vld_r),
    .in_val   (s7_sum_r),
    .in_pl    (s7_pl_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_pl   (sq_pl)
  );

  // Rounded quotient of each magnitude by the length
  logic             dv_vld;
  logic [QW-1:0]    dv_q0, dv_q1, dv_q2;
  logic [DV_PW-1:0] dv_pl;

  hvn_div #(
    .NORMAL_FRAC_BITS (F),
    .PW               (DV_PW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .in_m0   (sq_pl[3*MAG_W-1:2*MAG_W]),
    .in_m1   (sq_pl[2*MAG_W-1:MAG_W]),
    .in_m2   (sq_pl[MAG_W-1:0]),
    .in_len  (sq_root),
    .in_pl   (sq_pl[SQ_PW-1:3*MAG_W]),
    .out_vld (dv_vld),
    .out_q0  (dv_q0),
    .out_q1  (dv_q1),
    .out_q2  (dv_q2),
    .out_pl  (dv_pl)
  );

  // Final stage: clamp to one, apply sign, zero a degenerate face
  function automatic logic signed [QW-1:0] finish(input logic [QW-1:0] q,
                                                  input logic neg,
                                                  input logic zero);
    logic [QW-1:0] c;
    c = (q > (QW'(1) << F)) ? (QW'(1) << F) : q;
    if (zero) c = '0;
    return neg ? $signed(-c) : $signed(c);
  endfunction

  logic                 fn_vld_r, fn_tag_r;
  logic signed [QW-1:0] fn_x_r, fn_y_r, fn_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fn_vld_r <= 1'b0;
    end else if (en) begin
      fn_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fn_tag_r <= dv_pl[4];
      fn_x_r   <= finish(dv_q0, dv_pl[2], dv_pl[3]);
      fn_y_r   <= finish(dv_q1, dv_pl[1], dv_pl[3]);
      fn_z_r   <= finish(dv_q2, dv_pl[0], dv_pl[3]);
    end
  end

  assign out_vld = fn_vld_r;
  assign out_tag = fn_tag_r;
  assign out_nx  = fn_x_r;
  assign out_ny  = fn_y_r;
  assign out_nz  = fn_z_r;

endmodule

FILE: hw/rtl/heightmap_vertex_normal.sv
// Pipeline from input beat to output beat:
// 7 product/normalize stages, 31 square root stages, NORMAL_FRAC_BITS+2 divide
// stages, one finish stage per face and one averaging/output stage.
// Throughput: one beat per cycle; the whole pipeline stalls only while the
// output register holds a beat that is not taken. Reset (rst_n, synchronous)
// clears all valid bits and loads the spacing and height step registers.
`timescale 1ns / 1ps

module heightmap_vertex_normal #(
  parameter int HEIGHT_BITS = 8,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // height_center, height_prev_row, height_next_row, height_prev_col,
  // height_next_col, height_prev_row_prev_col, height_prev_row_next_col,
  // height_next_row_prev_col
  input  logic [8*HEIGHT_BITS-1:0]          in_tdata,
  // on_last_row, on_last_col, is_interior
  input  logic [2:0]                        in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // normal_x, normal_y, normal_z
  output logic [3*hvn_pkg::OUT_W-1:0]       out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [hvn_pkg::REG_W-1:0]         cfg_wdata
);
  import hvn_pkg::*;

  localparam int HB = HEIGHT_BITS;
  localparam int F  = NORMAL_FRAC_BITS;
  localparam int NW = F + 2;
  localparam int SW = F + 4;
  localparam int EW = (F + 5 > OUT_W + 1) ? F + 5 : OUT_W + 1;

  // Configuration registers
  logic [REG_W-1:0] row_spacing_r, column_spacing_r, height_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_spacing_r    <= ROW_SPACING_RST;
      column_spacing_r <= COLUMN_SPACING_RST;
      height_step_r    <= HEIGHT_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_ROW_SPACING:    row_spacing_r    <= cfg_wdata;
        REG_COLUMN_SPACING: column_spacing_r <= cfg_wdata;
        REG_HEIGHT_STEP:    height_step_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Unpack the input beat
  logic [HB-1:0] h_c, h_pr, h_nr, h_pc, h_nc, h_prpc, h_prnc, h_nrpc;
  logic          last_row, last_col, interior;

  assign h_c      = in_tdata[0*HB +: HB];
  assign h_pr     = in_tdata[1*HB +: HB];
  assign h_nr     = in_tdata[2*HB +: HB];
  assign h_pc     = in_tdata[3*HB +: HB];
  assign h_nc     = in_tdata[4*HB +: HB];
  assign h_prpc   = in_tdata[5*HB +: HB];
  assign h_prnc   = in_tdata[6*HB +: HB];
  assign h_nrpc   = in_tdata[7*HB +: HB];
  assign last_row = in_tuser[0];
  assign last_col = in_tuser[1];
  assign interior = in_tuser[2];

  // Advance the pipeline unless a finished beat waits at the output
  logic en, in_beat;
  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;
  assign in_beat   = in_tvalid & en;

  // Border points use their own face with neighbours picked by the flags
  logic [HB-1:0] f0_r, f0_q;
  logic          f0_rp, f0_cp;

  always_comb begin
    if (interior) begin
      f0_r  = h_nr;
      f0_q  = h_nc;
      f0_rp = 1'b0;
      f0_cp = 1'b0;
    end else begin
      f0_r  = last_row ? h_pr : h_nr;
      f0_q  = last_col ? h_pc : h_nc;
      f0_rp = last_row;
      f0_cp = last_col;
    end
  end

  logic                 fc_vld, fc_tag;
  logic signed [NW-1:0] n0x, n0y, n0z, n1x, n1y, n1z;
  logic signed [NW-1:0] n2x, n2y, n2z, n3x, n3y, n3z;

  hvn_face #(.HEIGHT_BITS(HB), .NORMAL_FRAC_BITS(F)) u_face0 (
    .clk (clk), .rst_n (rst_n), .en (en), .in_vld (in_beat), .in_tag (interior),
    .h_o (h_c), .h_r (f0_r), .h_q (f0_q), .row_prev (f0_rp), .col_prev (f0_cp),
    .row_spacing (row_spacing_r), .column_spacing (column_spacing_r),
    .height_step (height_step_r),
    .out_vld (fc_vld), .out_tag (fc_tag), .out_nx (n0x), .out_ny (n0y), .out_nz (n0z)
  );

  hvn_face #(.HEIGHT_BITS(HB), .NORMAL_FRAC_BITS(F)) u_face1 (
    .clk (clk), .rst_n (rst_n), .en (en), .in_vld (in_beat), .in_tag (interior),
    .h_o (h_pc), .h_r (h_nrpc), .h_q (h_c), .row_prev (1'b0), .col_prev (1'b0),
    .row_spacing (row_spacing_r), .column_spacing (column_spacing_r),
    .height_step (height_step_r),
    .out_vld (), .out_tag (), .out_nx (n1x), .out_ny (n1y), .out_nz (n1z)
  );

  hvn_face #(.HEIGHT_BITS(HB), .NORMAL_FRAC_BITS(F)) u_face2 (
    .clk (clk), .rst_n (rst_n), .en (en), .in_vld (in_beat), .in_tag (interior),
    .h_o (h_pr), .h_r (h_c), .h_q (h_prnc), .row_prev (1'b0), .col_prev (1'b0),
    .row_spacing (row_spacing_r), .column_spacing (column_spacing_r),
    .height_step (height_step_r),
    .out_vld (), .out_tag (), .out_nx (n2x), .out_ny (n2y), .out_nz (n2z)
  );

  hvn_face #(.HEIGHT_BITS(HB), .NORMAL_FRAC_BITS(F)) u_face3 (
    .clk (clk), .rst_n (rst_n), .en (en), .in_vld (in_beat), .in_tag (interior),
    .h_o (h_prpc), .h_r (h_pc), .h_q (h_pr), .row_prev (1'b0), .col_prev (1'b0),
    .row_spacing (row_spacing_r), .column_spacing (column_spacing_r),
    .height_step (height_step_r),
    .out_vld (), .out_tag (), .out_nx (n3x), .out_ny (n3y), .out_nz (n3z)
  );

  // Mean of four faces rounded half away from zero, or the single face,
  // then saturate to the output width
  function automatic logic [OUT_W-1:0] combine(input logic signed [NW-1:0] a,
                                               input logic signed [NW-1:0] b,
                                               input logic signed [NW-1:0] c,
                                               input logic signed [NW-1:0] d,
                                               input logic avg);
    logic signed [SW-1:0] s;
    logic [SW-1:0]        mag;
    logic [SW-1:0]        m;
    logic signed [EW-1:0] v;
    s   = SW'(a) + SW'(b) + SW'(c) + SW'(d);
    mag = s[SW-1] ? SW'(-s) : SW'(s);
    m   = (mag + SW'(2)) >> 2;
    if (avg) begin
      v = s[SW-1] ? -$signed(EW'(m)) : $signed(EW'(m));
    end else begin
      v = EW'(a);
    end
    if (v > $signed(EW'(32767))) begin
      v = EW'(32767);
    end else if (v < -$signed(EW'(32768))) begin
      v = -$signed(EW'(32768));
    end
    return v[OUT_W-1:0];
  endfunction

  logic             out_vld_r;
  logic [OUT_W-1:0] out_x_r, out_y_r, out_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= fc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r <= combine(n0x, n1x, n2x, n3x, fc_tag);
      out_y_r <= combine(n0y, n1y, n2y, n3y, fc_tag);
      out_z_r <= combine(n0z, n1z, n2z, n3z, fc_tag);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_z_r, out_y_r, out_x_r};

endmodule

FILE: hw/rtl/hvn_checker.sv
// Port-level checks for heightmap_vertex_normal, attached with bind.
// Depends on hvn_pkg for widths.
`timescale 1ns / 1ps

module hvn_checker #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic [3*hvn_pkg::OUT_W-1:0]     out_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready
);
  import hvn_pkg::*;

  localparam int LIM = ((1 << NORMAL_FRAC_BITS) > 32767) ? 32767 : (1 << NORMAL_FRAC_BITS);

  // A waiting output beat stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output data changed while stalled");

  // Input side is held off only by a stalled output beat
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // Every component is a unit-range normal
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(out_tdata[15:0])  <= LIM && $signed(out_tdata[15:0])  >= -LIM &&
       $signed(out_tdata[31:16]) <= LIM && $signed(out_tdata[31:16]) >= -LIM &&
       $signed(out_tdata[47:32]) <= LIM && $signed(out_tdata[47:32]) >= -LIM))
    else $error("normal component out of range");

endmodule

bind heightmap_vertex_normal hvn_checker #(
  .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_hvn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
